// ----- rtl/local_apic_timer_defines.svh -----
// assertion macros for the local apic timer
// no dependencies; included by the modules that assert
`ifndef LOCAL_APIC_TIMER_DEFINES_SVH
`define LOCAL_APIC_TIMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lapic_pkg.sv -----
// constants, command codes and divide decoding for the local apic timer
// no dependencies
package lapic_pkg;

    localparam logic [7:0] APIC_ID_VALUE = 8'h00;

    localparam int CMD_W = 2;
    localparam int OFF_W = 10;
    localparam int DATA_W = 32;
    localparam int VEC_W = 8;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    localparam logic [OFF_W-1:0] OFF_ID   = 10'h020;
    localparam logic [OFF_W-1:0] OFF_EOI  = 10'h0B0;
    localparam logic [OFF_W-1:0] OFF_SPUR = 10'h0F0;
    localparam logic [OFF_W-1:0] OFF_LVT  = 10'h320;
    localparam logic [OFF_W-1:0] OFF_INIT = 10'h380;
    localparam logic [OFF_W-1:0] OFF_CUR  = 10'h390;
    localparam logic [OFF_W-1:0] OFF_DIV  = 10'h3E0;

    localparam int LVT_MASK_POS = 16;
    localparam int LVT_PERIODIC_POS = 17;
    localparam int SPUR_ENABLE_POS = 8;
    localparam logic [3:0] DIV_CODE_BITS = 4'hB;

    // divisor from the divide code: bits {3,1,0} give n, 2^(n+1), n = 7 gives 1
    function automatic logic [7:0] divisor_of(input logic [3:0] code);
        logic [2:0] n;
        n = {code[3], code[1:0]};
        if (n == 3'd7)
            divisor_of = 8'd1;
        else
            divisor_of = 8'd2 << n;
    endfunction

endpackage

// ----- rtl/local_apic_timer.sv -----
// local apic timer: registered single-pass state update with an output register
// depends on lapic_pkg and local_apic_timer_defines.svh
//
// channel  dir  tvalid/tready          tdata / tuser
// s        in   s_tvalid, s_tready     tuser cmd; tdata reg_offset, write_data
// m        out  m_tvalid, m_tready     tdata read_data, irq_fire, irq_vector
//
// one item per cycle while the output is not stalled; each result appears in the cycle after its item is taken
// the counter, prescaler and register file update in the accepting cycle
// s_tready drops only while a result is held and m_tready is low
// rst_n clears all timer and register state to its reset values and empties the output register
`include "local_apic_timer_defines.svh"

module local_apic_timer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lapic_pkg::CMD_W-1:0]         s_tuser,   // cmd
    input  logic [lapic_pkg::IN_TDATA_W-1:0]    s_tdata,   // reg_offset, write_data, zero pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lapic_pkg::OUT_TDATA_W-1:0]   m_tdata    // read_data, irq_fire, irq_vector, zero pad
);
    import lapic_pkg::*;

    logic [3:0]        divide_code_reg, divide_code_next;
    logic [VEC_W-1:0]  lvt_vector_reg, lvt_vector_next;
    logic              lvt_masked_reg, lvt_masked_next;
    logic              lvt_periodic_reg, lvt_periodic_next;
    logic [DATA_W-1:0] initial_count_reg, initial_count_next;
    logic [DATA_W-1:0] current_count_reg, current_count_next;
    logic [6:0]        prescale_count_reg, prescale_count_next;
    logic [8:0]        spurious_reg, spurious_next;
    logic              in_service_reg, in_service_next;
    logic              expiry_pending_reg, expiry_pending_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic              irq_fire_reg;
    logic [VEC_W-1:0]  irq_vector_reg;

    logic [CMD_W-1:0]  cmd;
    logic [OFF_W-1:0]  off;
    logic [DATA_W-1:0] wdata;
    logic              accept;
    logic [DATA_W-1:0] rdata_c;
    logic              fire_c;
    logic [VEC_W-1:0]  vec_c;
    logic [7:0]        presc_inc;
    logic [DATA_W-1:0] count_dec;
    logic              enabled;

    assign cmd    = s_tuser;
    assign off    = {s_tdata[OFF_W-1:2], 2'b00};
    assign wdata  = s_tdata[OFF_W+DATA_W-1:OFF_W];
    assign s_tready = !out_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;

    assign presc_inc = {1'b0, prescale_count_reg} + 8'd1;
    assign count_dec = current_count_reg - 32'd1;
    assign enabled   = !lvt_masked_reg && spurious_reg[SPUR_ENABLE_POS];

    always_comb
    begin
        divide_code_next    = divide_code_reg;
        lvt_vector_next     = lvt_vector_reg;
        lvt_masked_next     = lvt_masked_reg;
        lvt_periodic_next   = lvt_periodic_reg;
        initial_count_next  = initial_count_reg;
        current_count_next  = current_count_reg;
        prescale_count_next = prescale_count_reg;
        spurious_next       = spurious_reg;
        in_service_next     = in_service_reg;
        expiry_pending_next = expiry_pending_reg;
        rdata_c = '0;
        fire_c  = 1'b0;
        vec_c   = '0;
        case (cmd)
            CMD_TICK:
            begin
                if (current_count_reg != '0)
                begin
                    if (presc_inc >= divisor_of(divide_code_reg))
                    begin
                        prescale_count_next = '0;
                        current_count_next  = count_dec;
                        if (count_dec == '0)
                        begin
                            if (lvt_periodic_reg)
                                current_count_next = initial_count_reg;
                            if (enabled)
                            begin
                                if (in_service_reg)
                                    expiry_pending_next = 1'b1;
                                else
                                begin
                                    in_service_next = 1'b1;
                                    fire_c = 1'b1;
                                    vec_c  = lvt_vector_reg;
                                end
                            end
                        end
                    end
                    else
                        prescale_count_next = presc_inc[6:0];
                end
            end
            CMD_READ:
            begin
                unique case (off)
                    OFF_ID:   rdata_c = {APIC_ID_VALUE, 24'd0};
                    OFF_SPUR: rdata_c = {23'd0, spurious_reg};
                    OFF_LVT:  rdata_c = {14'd0, lvt_periodic_reg, lvt_masked_reg,
                                         8'd0, lvt_vector_reg};
                    OFF_INIT: rdata_c = initial_count_reg;
                    OFF_CUR:  rdata_c = current_count_reg;
                    OFF_DIV:  rdata_c = {28'd0, divide_code_reg};
                    default:  rdata_c = '0;
                endcase
            end
            CMD_WRITE:
            begin
                unique case (off)
                    OFF_EOI:
                    begin
                        in_service_next = 1'b0;
                        if (expiry_pending_reg)
                        begin
                            expiry_pending_next = 1'b0;
                            in_service_next = 1'b1;
                            fire_c = 1'b1;
                            vec_c  = lvt_vector_reg;
                        end
                    end
                    OFF_SPUR: spurious_next = wdata[8:0];
                    OFF_LVT:
                    begin
                        lvt_vector_next   = wdata[VEC_W-1:0];
                        lvt_masked_next   = wdata[LVT_MASK_POS];
                        lvt_periodic_next = wdata[LVT_PERIODIC_POS];
                    end
                    OFF_INIT:
                    begin
                        initial_count_next  = wdata;
                        current_count_next  = wdata;
                        prescale_count_next = '0;
                    end
                    OFF_DIV:  divide_code_next = wdata[3:0] & DIV_CODE_BITS;
                    default:  ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divide_code_reg    <= '0;
            lvt_vector_reg     <= '0;
            lvt_masked_reg     <= 1'b1;
            lvt_periodic_reg   <= 1'b0;
            initial_count_reg  <= '0;
            current_count_reg  <= '0;
            prescale_count_reg <= '0;
            spurious_reg       <= 9'h0FF;
            in_service_reg     <= 1'b0;
            expiry_pending_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                divide_code_reg    <= divide_code_next;
                lvt_vector_reg     <= lvt_vector_next;
                lvt_masked_reg     <= lvt_masked_next;
                lvt_periodic_reg   <= lvt_periodic_next;
                initial_count_reg  <= initial_count_next;
                current_count_reg  <= current_count_next;
                prescale_count_reg <= prescale_count_next;
                spurious_reg       <= spurious_next;
                in_service_reg     <= in_service_next;
                expiry_pending_reg <= expiry_pending_next;
                out_valid_reg      <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg  <= rdata_c;
            irq_fire_reg   <= fire_c;
            irq_vector_reg <= vec_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, irq_vector_reg, irq_fire_reg, read_data_reg};

    `LAT_ASSERT_NEXT(a_fire_sets_service, accept && fire_c, in_service_reg, "irq delivered but in-service not set")
    `LAT_ASSERT_NOW(a_pending_in_service, expiry_pending_reg, in_service_reg, "expiry held while nothing in service")
    `LAT_ASSERT_NOW(a_stall_blocks_input, out_valid_reg && !m_tready, !s_tready, "input taken while result stalled")
    `LAT_ASSERT_NEXT(a_stopped_stays, accept && cmd == CMD_TICK && current_count_reg == '0, current_count_reg == '0, "stopped counter moved on a tick")

endmodule
